@@ src/assert_macros.svh @@
// assertion macros shared by the checker files
// no dependencies; included by files that carry concurrent assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on the same edge, masked while in reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// non-overlapping implication, masked while in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

// non-overlapping implication checked from every edge, reset included
`define ASSERT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ src/mhpq_pkg.sv @@
// shared types, widths and codes of the max-heap priority queue
// no dependencies; imported by every module of the block
package mhpq_pkg;

  localparam int CAPACITY    = 256;
  localparam int KEY_W       = 32;
  localparam int ADDR_W      = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int ACT_W       = 2;
  localparam int STAT_W      = 2;
  localparam int OUT_TDATA_W = ((KEY_W + CNT_W + 7) / 8) * 8;

  // request actions
  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_LOAD   = 2'd2;
  localparam logic [ACT_W-1:0] ACT_BUILD  = 2'd3;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  // key store access: write and read request
  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [KEY_W-1:0]  wr_data;
    logic [ADDR_W-1:0] rd_addr;
  } mem_req_t;

  // finished result offered by the sequencer
  typedef struct packed {
    logic              valid;
    logic [KEY_W-1:0]  removed_key;
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  element_count;
  } res_t;

endpackage

@@ src/max_heap_priority_queue_core.sv @@
// top level of the max-heap priority queue: stream ports and output register
// depends on mhpq_pkg, mhpq_store and mhpq_seq
//
// Usage: each request on the in_ channel carries an action in in_tuser
// (insert, remove max, load raw, build) and a signed 32-bit key in in_tdata.
// Every request gives exactly one result on the out_ channel: the removed
// key (zero unless a remove succeeded), a status in out_tuser (ok, empty on
// remove, full on insert or load) and the key count after the request.
// Requests are taken one at a time; the sequencer reads the key store at most
// once per cycle through a single read port, so the cost is set by that port:
// load, a rejected request or a build under two keys read nothing; insert
// reads each parent it compares; remove reads the root, then the last key,
// then both children per level descended; build runs that sift-down from
// each parent, from the last one down to the root.
// The output register lets the next request enter while a result waits;
// a stalled receiver holds out_tvalid and the payload, and the sequencer
// then waits with its finished result until the register frees.
// Reset (rst_n low, synchronous) empties the heap and drops any pending
// result; the key store itself is not cleared.
module max_heap_priority_queue_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [31:0]                       in_tdata,  // key_value[31:0]
  input  logic [mhpq_pkg::ACT_W-1:0]        in_tuser,  // action[1:0]
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [mhpq_pkg::OUT_TDATA_W-1:0]  out_tdata, // removed_key[31:0], element_count[40:32]
  output logic [mhpq_pkg::STAT_W-1:0]       out_tuser  // status[1:0]
);
  import mhpq_pkg::*;

  mem_req_t         mem_req;
  logic [KEY_W-1:0] rd_data;
  res_t             res;
  logic             res_take;

  logic              out_valid_r;
  logic [KEY_W-1:0]  out_key_r;
  logic [STAT_W-1:0] out_status_r;
  logic [CNT_W-1:0]  out_count_r;

  mhpq_store u_store (
    .clk     (clk),
    .mem_req (mem_req),
    .rd_data (rd_data)
  );

  mhpq_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_action (in_tuser),
    .in_key    (in_tdata[KEY_W-1:0]),
    .in_ready  (in_tready),
    .mem_req   (mem_req),
    .rd_data   (rd_data),
    .res       (res),
    .res_take  (res_take)
  );

  // result moves into the output register when it is free or being drained
  assign res_take = res.valid && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (res_take) begin
      out_key_r    <= res.removed_key;
      out_status_r <= res.status;
      out_count_r  <= res.element_count;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - KEY_W - CNT_W){1'b0}}, out_count_r, out_key_r};
  assign out_tuser  = out_status_r;

endmodule

@@ src/mhpq_store.sv @@
// key store: one write port and one read port with registered read data
// depends on mhpq_pkg
module mhpq_store (
  input  logic                      clk,
  input  mhpq_pkg::mem_req_t        mem_req,
  output logic [mhpq_pkg::KEY_W-1:0] rd_data
);
  import mhpq_pkg::*;

  logic [KEY_W-1:0] mem [CAPACITY];
  logic [KEY_W-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (mem_req.wr_en) begin
      mem[mem_req.wr_addr] <= mem_req.wr_data;
    end
  end

  // read port, data in the cycle after the address
  always_ff @(posedge clk) begin
    rd_data_r <= mem[mem_req.rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ src/mhpq_seq.sv @@
// heap sequencer: sift-up, sift-down and build over one shared signed comparator
// depends on mhpq_pkg; drives the key store through mem_req_t
module mhpq_seq (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [mhpq_pkg::ACT_W-1:0]  in_action,
  input  logic [mhpq_pkg::KEY_W-1:0]  in_key,
  output logic                        in_ready,
  output mhpq_pkg::mem_req_t          mem_req,
  input  logic [mhpq_pkg::KEY_W-1:0]  rd_data,
  output mhpq_pkg::res_t              res,
  input  logic                        res_take
);
  import mhpq_pkg::*;

  localparam int IDX_W = ADDR_W + 2;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_UP_RD   = 4'd1;
  localparam logic [3:0] S_UP_CMP  = 4'd2;
  localparam logic [3:0] S_RM_ROOT = 4'd3;
  localparam logic [3:0] S_LD_KEY  = 4'd4;
  localparam logic [3:0] S_DN_L    = 4'd5;
  localparam logic [3:0] S_DN_R    = 4'd6;
  localparam logic [3:0] S_DN_CMP  = 4'd7;
  localparam logic [3:0] S_DN_END  = 4'd8;
  localparam logic [3:0] S_DONE    = 4'd9;

  logic [3:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic [ADDR_W-1:0] pos_r, pos_nxt;
  logic [ADDR_W-1:0] bidx_r, bidx_nxt;
  logic [ACT_W-1:0]  mode_r, mode_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [KEY_W-1:0]  lval_r, lval_nxt;
  logic              lbig_r, lbig_nxt;
  logic              rok_r, rok_nxt;
  logic [KEY_W-1:0]  removed_r, removed_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;

  logic [KEY_W-1:0]  cmp_a, cmp_b;
  logic              cmp_gt;
  logic [IDX_W-1:0]  lft, rgt, n_ext;
  logic [ADDR_W-1:0] parent;
  logic [KEY_W-1:0]  bigval;

  // child and parent indexes of the current position
  assign lft    = {1'b0, pos_r, 1'b1};
  assign rgt    = lft + IDX_W'(1);
  assign n_ext  = IDX_W'(n_r);
  assign parent = (pos_r - ADDR_W'(1)) >> 1;
  assign bigval = lbig_r ? lval_r : key_r;

  // shared signed comparator: a strictly greater than b
  assign cmp_gt = $signed(cmp_a) > $signed(cmp_b);

  always_comb begin
    cmp_a = rd_data;
    cmp_b = key_r;
    case (state_r)
      S_UP_CMP: begin
        cmp_a = key_r;
        cmp_b = rd_data;
      end
      S_DN_CMP: begin
        cmp_a = rd_data;
        cmp_b = bigval;
      end
      default: begin
        cmp_a = rd_data;
        cmp_b = key_r;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    n_nxt       = n_r;
    pos_nxt     = pos_r;
    bidx_nxt    = bidx_r;
    mode_nxt    = mode_r;
    key_nxt     = key_r;
    lval_nxt    = lval_r;
    lbig_nxt    = lbig_r;
    rok_nxt     = rok_r;
    removed_nxt = removed_r;
    status_nxt  = status_r;
    mem_req     = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          mode_nxt    = in_action;
          key_nxt     = in_key;
          removed_nxt = '0;
          status_nxt  = ST_OK;
          state_nxt   = S_DONE;
          case (in_action)
            ACT_INSERT: begin
              if (cnt_r == CNT_W'(CAPACITY)) begin
                status_nxt = ST_FULL;
              end else begin
                pos_nxt   = cnt_r[ADDR_W-1:0];
                cnt_nxt   = cnt_r + CNT_W'(1);
                state_nxt = S_UP_RD;
              end
            end
            ACT_LOAD: begin
              if (cnt_r == CNT_W'(CAPACITY)) begin
                status_nxt = ST_FULL;
              end else begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = cnt_r[ADDR_W-1:0];
                mem_req.wr_data = in_key;
                cnt_nxt         = cnt_r + CNT_W'(1);
              end
            end
            ACT_REMOVE: begin
              if (cnt_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                mem_req.rd_addr = '0;
                cnt_nxt         = cnt_r - CNT_W'(1);
                n_nxt           = cnt_r - CNT_W'(1);
                pos_nxt         = '0;
                state_nxt       = S_RM_ROOT;
              end
            end
            default: begin
              // build: heapify from the last parent down to the root
              if (cnt_r >= CNT_W'(2)) begin
                n_nxt           = cnt_r;
                bidx_nxt        = ADDR_W'((cnt_r >> 1) - CNT_W'(1));
                pos_nxt         = ADDR_W'((cnt_r >> 1) - CNT_W'(1));
                mem_req.rd_addr = ADDR_W'((cnt_r >> 1) - CNT_W'(1));
                state_nxt       = S_LD_KEY;
              end
            end
          endcase
        end
      end

      // sift-up: hole moves toward the root
      S_UP_RD: begin
        if (pos_r == '0) begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = pos_r;
          mem_req.wr_data = key_r;
          state_nxt       = S_DONE;
        end else begin
          mem_req.rd_addr = parent;
          state_nxt       = S_UP_CMP;
        end
      end

      S_UP_CMP: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = pos_r;
        if (cmp_gt) begin
          mem_req.wr_data = rd_data;
          pos_nxt         = parent;
          state_nxt       = S_UP_RD;
        end else begin
          mem_req.wr_data = key_r;
          state_nxt       = S_DONE;
        end
      end

      // remove: root leaves, last key starts at the root
      S_RM_ROOT: begin
        removed_nxt     = rd_data;
        mem_req.rd_addr = n_r[ADDR_W-1:0];
        state_nxt       = S_LD_KEY;
      end

      S_LD_KEY: begin
        key_nxt   = rd_data;
        state_nxt = S_DN_L;
      end

      // sift-down: fetch left child or settle at a leaf
      S_DN_L: begin
        if (lft >= n_ext) begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = pos_r;
          mem_req.wr_data = key_r;
          state_nxt       = S_DN_END;
        end else begin
          mem_req.rd_addr = lft[ADDR_W-1:0];
          state_nxt       = S_DN_R;
        end
      end

      S_DN_R: begin
        lval_nxt        = rd_data;
        lbig_nxt        = cmp_gt;
        rok_nxt         = rgt < n_ext;
        mem_req.rd_addr = rgt[ADDR_W-1:0];
        state_nxt       = S_DN_CMP;
      end

      S_DN_CMP: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = pos_r;
        if (rok_r && cmp_gt) begin
          mem_req.wr_data = rd_data;
          pos_nxt         = rgt[ADDR_W-1:0];
          state_nxt       = S_DN_L;
        end else if (lbig_r) begin
          mem_req.wr_data = lval_r;
          pos_nxt         = lft[ADDR_W-1:0];
          state_nxt       = S_DN_L;
        end else begin
          mem_req.wr_data = key_r;
          state_nxt       = S_DN_END;
        end
      end

      // next build index or finish
      S_DN_END: begin
        if (mode_r == ACT_BUILD && bidx_r != '0) begin
          bidx_nxt        = bidx_r - ADDR_W'(1);
          pos_nxt         = bidx_r - ADDR_W'(1);
          mem_req.rd_addr = bidx_r - ADDR_W'(1);
          state_nxt       = S_LD_KEY;
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    n_r       <= n_nxt;
    pos_r     <= pos_nxt;
    bidx_r    <= bidx_nxt;
    mode_r    <= mode_nxt;
    key_r     <= key_nxt;
    lval_r    <= lval_nxt;
    lbig_r    <= lbig_nxt;
    rok_r     <= rok_nxt;
    removed_r <= removed_nxt;
    status_r  <= status_nxt;
  end

  assign in_ready          = (state_r == S_IDLE);
  assign res.valid         = (state_r == S_DONE);
  assign res.removed_key   = removed_r;
  assign res.status        = status_r;
  assign res.element_count = cnt_r;

endmodule

@@ src/mhpq_chk.sv @@
// port-level checker for the max-heap priority queue, bound to the top level
// depends on mhpq_pkg and assert_macros.svh
`include "assert_macros.svh"

module mhpq_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [mhpq_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input logic [mhpq_pkg::STAT_W-1:0]       out_tuser
);
  import mhpq_pkg::*;

  logic [CNT_W-1:0] out_count;
  logic [KEY_W-1:0] out_key;

  assign out_count = out_tdata[KEY_W +: CNT_W];
  assign out_key   = out_tdata[KEY_W-1:0];

  // stalled result stays offered
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)

  // stalled result keeps its payload
  `ASSERT_NEXT(a_out_stable, clk, rst_n, out_tvalid && !out_tready,
               $stable(out_tdata) && $stable(out_tuser))

  // count never passes the capacity
  `ASSERT_IMPLY(a_count_max, clk, rst_n, out_tvalid, out_count <= CNT_W'(CAPACITY))

  // empty remove reports no key and no keys held
  `ASSERT_IMPLY(a_empty_zero, clk, rst_n, out_tvalid && out_tuser == ST_EMPTY,
                out_key == '0 && out_count == '0)

  // no result right after reset
  `ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n, !out_tvalid)

endmodule

bind max_heap_priority_queue_core mhpq_chk u_mhpq_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
